[sv/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and the power-on phase table of the character LCD
// nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

   // Operation codes carried in the request beat.
   typedef enum logic [2:0] {
      OP_RESET       = 3'd0,
      OP_RAW_BYTE    = 3'd1,
      OP_CLEAR       = 3'd2,
      OP_TEXT        = 3'd3,
      OP_SECOND_LINE = 3'd4
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PULSE_MS    = 2'd0,
      CSR_LINE_LENGTH = 2'd1,
      CSR_LINE2_ADDR  = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // How the hold time of a phase is formed.
   typedef enum logic [1:0] {
      HOLD_PULSE,
      HOLD_PULSE_PLUS1,
      HOLD_PULSE_PLUS5,
      HOLD_FIXED_15
   } hold_kind_type;

   // One pin phase before its hold time is worked out.
   typedef struct packed {
      logic          rs;
      logic [3:0]    nibble;
      logic          enable;
      hold_kind_type hold_kind;
   } phase_spec_type;

   localparam int STEP_W = 5;

   localparam logic [STEP_W-1:0] RESET_LAST_STEP = 5'd28;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd3;
   localparam logic [STEP_W-1:0] INIT_STEPS      = 5'd9;

   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic       SET_DDRAM_FLAG  = 1'b1;
   localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [3:0] NIB_WAKE        = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
   localparam logic [7:0] FIXED_HOLD_MS   = 8'd15;

   // Phase of the power-on sequence at a given step. The first nine steps
   // are the wake-up nibbles; the rest are five command bytes of four
   // phases each.
   function automatic phase_spec_type lcdns_reset_phase(input logic [STEP_W-1:0] step);
      phase_spec_type     ph;
      logic [STEP_W-1:0]  idx;
      logic [7:0]         cmd;
      idx = step - INIT_STEPS;
      ph.rs        = 1'b0;
      ph.nibble    = NIB_WAKE;
      ph.enable    = 1'b0;
      ph.hold_kind = HOLD_PULSE;
      cmd          = CMD_FUNC_SET;
      if (step < INIT_STEPS) begin
         unique case (step[3:0])
            4'd0: begin
               ph.hold_kind = HOLD_FIXED_15;
            end
            4'd1, 4'd3, 4'd5: begin
               ph.enable = 1'b1;
            end
            4'd2: begin
               ph.hold_kind = HOLD_PULSE_PLUS5;
            end
            4'd4: begin
               ph.hold_kind = HOLD_PULSE_PLUS1;
            end
            4'd7: begin
               ph.nibble = NIB_FOUR_BIT;
               ph.enable = 1'b1;
            end
            4'd8: begin
               ph.nibble = NIB_FOUR_BIT;
            end
            default: begin
               ph.hold_kind = HOLD_PULSE;
            end
         endcase
      end else begin
         unique case (idx[4:2])
            3'd0:    cmd = CMD_FUNC_SET;
            3'd1:    cmd = CMD_DISPLAY_OFF;
            3'd2:    cmd = CMD_CLEAR;
            3'd3:    cmd = CMD_ENTRY_MODE;
            default: cmd = CMD_DISPLAY_ON;
         endcase
         ph.nibble = idx[1] ? cmd[3:0] : cmd[7:4];
         ph.enable = ~idx[0];
         // The clear command needs a longer settle after its last phase.
         if (idx[4:2] == 3'd2 && idx[1:0] == 2'd3) begin
            ph.hold_kind = HOLD_PULSE_PLUS1;
         end
      end
      return ph;
   endfunction

endpackage

[sv/lcdns_phase_sel.sv]
// ----------------------------------------------------------------------------
// lcdns_phase_sel
// Picks the pin levels and hold kind of the current phase, either from the
// power-on table or from the byte being sent.
// ----------------------------------------------------------------------------
module lcdns_phase_sel
   import lcdns_pkg::*;
(
   input  logic [STEP_W-1:0] step,
   input  logic              is_reset,
   input  logic              byte_rs,
   input  logic [7:0]        byte_value,
   output phase_spec_type    phase
);

   // A plain byte is high nibble then low nibble, each enable high then low.
   always_comb begin
      if (is_reset) begin
         phase = lcdns_reset_phase(step);
      end else begin
         phase.rs        = byte_rs;
         phase.nibble    = step[1] ? byte_value[3:0] : byte_value[7:4];
         phase.enable    = ~step[0];
         phase.hold_kind = HOLD_PULSE;
      end
   end

endmodule

[sv/lcdns_hold_unit.sv]
// ----------------------------------------------------------------------------
// lcdns_hold_unit
// Shared adder that forms the hold time of every phase, saturating at 255.
// ----------------------------------------------------------------------------
module lcdns_hold_unit
   import lcdns_pkg::*;
(
   input  logic [7:0]    pulse_ms,
   input  hold_kind_type hold_kind,
   output logic [7:0]    hold_ms
);

   logic [7:0] extra;
   logic [8:0] sum;

   // Extra time added to the pulse, then clamp on carry out.
   always_comb begin
      unique case (hold_kind)
         HOLD_PULSE_PLUS1: extra = 8'd1;
         HOLD_PULSE_PLUS5: extra = 8'd5;
         default:          extra = 8'd0;
      endcase
      sum = {1'b0, pulse_ms} + {1'b0, extra};
      if (hold_kind == HOLD_FIXED_15) begin
         hold_ms = FIXED_HOLD_MS;
      end else begin
         hold_ms = sum[8] ? 8'hFF : sum[7:0];
      end
   end

endmodule

[sv/char_lcd_nibble_sequencer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// Turns LCD operations into a stream of 4-bit bus pin phases.
//
//   Port group  Direction  Beat contents
//   req_*       in         operation, data byte; tuser register select
//   rsp_*       out        nibble, enable, hold ms; tuser rs; tlast end of item
//   csr_*       in         register writes, no read-back
//
// One phase leaves per cycle through the output register while the output
// is free; the step counter of the sequencer sets the pace. A request is
// taken while idle, then a reset operation emits its 29 phases and the other
// operations their 4 phases, and no new request is taken before the last
// phase has been issued. A dropped character or unknown code gives no beat.
// req_tready is low while a sequence runs. A stall on rsp_tready holds
// the current phase and the step counter.
// Reset is synchronous and active high; no memory needs clearing.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top
   import lcdns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] operation, [10:3] data_byte, rest zero
   input  logic        req_tuser,   // [0] register_select
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] data_nibble, [4] enable_level, [12:5] hold_ms
   output logic        rsp_tuser,   // [0] rs_level
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] last_step_ff, last_step_in;
   logic              is_reset_ff, is_reset_in;
   logic              byte_rs_ff, byte_rs_in;
   logic [7:0]        byte_ff, byte_in;

   logic [7:0]        pulse_ms_ff;
   logic [5:0]        line_length_ff;
   logic [6:0]        line2_addr_ff;
   logic [5:0]        column_ff, column_in;
   logic              second_line_ff, second_line_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_rs_ff, out_rs_in;
   logic [3:0]        out_nibble_ff, out_nibble_in;
   logic              out_enable_ff, out_enable_in;
   logic [7:0]        out_hold_ff, out_hold_in;
   logic              out_last_ff, out_last_in;

   phase_spec_type    phase;
   logic [7:0]        hold_ms;
   logic              req_fire;
   logic              out_free;
   op_type            req_op;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign req_op     = op_type'(req_tdata[2:0]);

   // Phase selection and the shared hold-time adder.
   lcdns_phase_sel u_phase_sel (
      .step       (step_ff),
      .is_reset   (is_reset_ff),
      .byte_rs    (byte_rs_ff),
      .byte_value (byte_ff),
      .phase      (phase)
   );

   lcdns_hold_unit u_hold_unit (
      .pulse_ms  (pulse_ms_ff),
      .hold_kind (phase.hold_kind),
      .hold_ms   (hold_ms)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ms_ff    <= 8'd1;
         line_length_ff <= 6'd16;
         line2_addr_ff  <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PULSE_MS:    pulse_ms_ff    <= csr_wdata;
            CSR_LINE_LENGTH: line_length_ff <= csr_wdata[5:0];
            CSR_LINE2_ADDR:  line2_addr_ff  <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state, cursor state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         column_ff      <= '0;
         second_line_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         column_ff      <= column_in;
         second_line_ff <= second_line_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_step_ff  <= last_step_in;
      is_reset_ff   <= is_reset_in;
      byte_rs_ff    <= byte_rs_in;
      byte_ff       <= byte_in;
      out_rs_ff     <= out_rs_in;
      out_nibble_ff <= out_nibble_in;
      out_enable_ff <= out_enable_in;
      out_hold_ff   <= out_hold_in;
      out_last_ff   <= out_last_in;
   end

   // Next state: decode a request when idle, emit one phase per free cycle.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      last_step_in   = last_step_ff;
      is_reset_in    = is_reset_ff;
      byte_rs_in     = byte_rs_ff;
      byte_in        = byte_ff;
      column_in      = column_ff;
      second_line_in = second_line_ff;
      out_valid_in   = out_valid_ff & ~rsp_tready;
      out_rs_in      = out_rs_ff;
      out_nibble_in  = out_nibble_ff;
      out_enable_in  = out_enable_ff;
      out_hold_in    = out_hold_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            step_in      = '0;
            last_step_in = BYTE_LAST_STEP;
            is_reset_in  = 1'b0;
            if (req_fire) begin
               unique case (req_op)
                  OP_RESET: begin
                     state_in       = ST_RUN;
                     is_reset_in    = 1'b1;
                     last_step_in   = RESET_LAST_STEP;
                     column_in      = '0;
                     second_line_in = 1'b0;
                  end
                  OP_RAW_BYTE: begin
                     state_in   = ST_RUN;
                     byte_rs_in = req_tuser;
                     byte_in    = req_tdata[10:3];
                  end
                  OP_CLEAR: begin
                     state_in       = ST_RUN;
                     byte_rs_in     = 1'b0;
                     byte_in        = CMD_CLEAR;
                     column_in      = '0;
                     second_line_in = 1'b0;
                  end
                  OP_TEXT: begin
                     // Characters past the end of the line are dropped.
                     if (column_ff < line_length_ff) begin
                        state_in   = ST_RUN;
                        byte_rs_in = 1'b1;
                        byte_in    = req_tdata[10:3];
                        column_in  = column_ff + 6'd1;
                     end
                  end
                  OP_SECOND_LINE: begin
                     state_in       = ST_RUN;
                     byte_rs_in     = 1'b0;
                     byte_in        = {SET_DDRAM_FLAG, line2_addr_ff};
                     column_in      = '0;
                     second_line_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_rs_in     = phase.rs;
               out_nibble_in = phase.nibble;
               out_enable_in = phase.enable;
               out_hold_in   = hold_ms;
               out_last_in   = (step_ff == last_step_ff);
               step_in       = step_ff + 5'd1;
               if (step_ff == last_step_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_hold_ff, out_enable_ff, out_nibble_ff};
   assign rsp_tuser  = out_rs_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   // The step counter never runs past the end of its sequence.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= last_step_ff))
      else $error("step counter beyond end of sequence");

   // A move to line two always leaves the column at zero.
   a_line2_column: assert property (@(posedge clock) disable iff (reset)
      $rose(second_line_ff) |-> (column_ff == 6'd0))
      else $error("column not cleared on second line move");

   // The final phase of an item returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && out_free && step_ff == last_step_ff)
      |=> (state_ff == ST_IDLE && rsp_tlast && rsp_tvalid))
      else $error("sequence end not marked or not idle");
`endif

endmodule
